>>> hdl/kpr_pkg.sv
// kpr_pkg: shared types and constants for the gamepad key repeat block.
// No dependencies; used by kpr_slot, kpr_dir and the top level.
`default_nettype none

package kpr_pkg;

  localparam int NumButtons = 8;
  localparam int NumDirs    = 4;
  localparam int NumSlots   = NumButtons + NumDirs;
  localparam int SrcW       = 4;
  localparam int TimeBits   = 32;
  localparam int AxisW      = 15;
  localparam int MsW        = 16;
  localparam int StickW     = 16;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgOnLevel  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOffLevel = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDelay    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgInterval = 2'd3;

  localparam logic [AxisW-1:0] OnLevelRst  = 15'd16384;
  localparam logic [AxisW-1:0] OffLevelRst = 15'd11469;
  localparam logic [MsW-1:0]   DelayRst    = 16'd400;
  localparam logic [MsW-1:0]   IntervalRst = 16'd140;

  // direction slots follow the buttons: left, right, up, down
  localparam logic [SrcW-1:0] SrcLeft = SrcW'(NumButtons);

  typedef logic [TimeBits-1:0] time_t;

  typedef struct packed {
    logic            valid;
    logic [SrcW-1:0] src;
    logic            press;
    logic            rep;
  } ev_t;

  typedef struct packed {
    ev_t  ev;
    logic last;
  } slot_t;

  typedef struct packed {
    logic [AxisW-1:0] on_level;
    logic [AxisW-1:0] off_level;
    logic [MsW-1:0]   delay_ms;
    logic [MsW-1:0]   interval_ms;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/kpr_slot.sv
// kpr_slot: one event slot of the output chain; loads a fresh event or
// takes its right neighbor's slot. Depends on kpr_pkg.
`default_nettype none

module kpr_slot (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  wire                 shift,
  input  wire kpr_pkg::ev_t   new_ev,
  input  wire                 later_in,   // a loaded event sits further right
  input  wire kpr_pkg::slot_t right_slot,
  output logic                later_out,
  output kpr_pkg::slot_t      slot_q
);

  kpr_pkg::slot_t slot_r, slot_nxt;

  assign later_out = later_in | new_ev.valid;
  assign slot_q    = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (load) begin
      slot_nxt.ev   = new_ev;
      slot_nxt.last = new_ev.valid & ~later_in;
    end else if (shift) begin
      slot_nxt = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.ev.valid <= 1'b0;
    end else begin
      slot_r.ev.valid <= slot_nxt.ev.valid;
    end
    slot_r.ev.src   <= slot_nxt.ev.src;
    slot_r.ev.press <= slot_nxt.ev.press;
    slot_r.ev.rep   <= slot_nxt.ev.rep;
    slot_r.last     <= slot_nxt.last;
  end

endmodule

`default_nettype wire

>>> hdl/kpr_dir.sv
// kpr_dir: one direction: stick hysteresis, active flag and repeat timers.
// Depends on kpr_pkg.
`default_nettype none

module kpr_dir (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            accept,
  input  wire kpr_pkg::cfg_t             cfg,
  input  wire                            dpad,
  input  wire signed [kpr_pkg::StickW-1:0] stick,
  input  wire                            neg_side,  // left/up trigger below -thr
  input  wire kpr_pkg::time_t            now,
  input  wire                            emit,
  input  wire [kpr_pkg::SrcW-1:0]        src,
  output kpr_pkg::ev_t                   ev
);

  logic                 active_r, active_nxt;
  kpr_pkg::time_t       pressed_r, repeat_r;
  logic [kpr_pkg::AxisW-1:0] thr;
  logic signed [kpr_pkg::StickW:0] s_ext, t_ext;
  logic                 want, rep_ok;
  kpr_pkg::time_t       held, since;

  assign thr   = active_r ? cfg.off_level : cfg.on_level;
  assign s_ext = {stick[kpr_pkg::StickW-1], stick};
  assign t_ext = {2'b00, thr};
  assign want  = dpad | (neg_side ? (s_ext < -t_ext) : (s_ext > t_ext));

  assign held   = now - pressed_r;
  assign since  = now - repeat_r;
  assign rep_ok = (held  >= {{(kpr_pkg::TimeBits-kpr_pkg::MsW){1'b0}}, cfg.delay_ms}) &&
                  (since >= {{(kpr_pkg::TimeBits-kpr_pkg::MsW){1'b0}}, cfg.interval_ms});

  assign active_nxt = accept ? want : active_r;

  always_comb begin
    ev.valid = emit & ((want ^ active_r) | (want & active_r & rep_ok));
    ev.src   = src;
    ev.press = want;
    ev.rep   = want & active_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  // timers only matter while active, and a press always writes them
  always_ff @(posedge clk) begin
    if (accept && want && !active_r) begin
      pressed_r <= now;
      repeat_r  <= now;
    end else if (accept && want && rep_ok) begin
      repeat_r  <= now;
    end
  end

endmodule

`default_nettype wire

>>> hdl/gamepad_key_repeat_hysteresis_top.sv
// gamepad_key_repeat_hysteresis_top: controller sample to key events.
// Depends on kpr_pkg, kpr_slot and kpr_dir.
`default_nettype none

// Each accepted sample is decoded in the cycle it is accepted: button edges
// and direction press/release/repeat events are loaded into a chain of
// twelve event slots (buttons 0..7, then left, right, up, down). The chain
// shifts one slot per cycle toward a registered output stage while that
// stage can advance. A sample with no events, or without focus, leaves the
// chain empty. The next sample is taken as soon as only the head slot still
// holds an event and the output stage can advance; while a result waits on
// out_ready the chain holds and the input is held off. The final event of a
// sample carries out_last. Timestamps wrap modulo 2^32. Configuration writes
// take effect at once and should only be made while no events are pending.
module gamepad_key_repeat_hysteresis_top (
  input  wire                              clk,
  input  wire                              rst_n,
  // sample channel
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [kpr_pkg::NumButtons-1:0]    in_button_levels,
  input  wire                              in_dpad_up,
  input  wire                              in_dpad_down,
  input  wire                              in_dpad_left,
  input  wire                              in_dpad_right,
  input  wire signed [kpr_pkg::StickW-1:0] in_stick_x,
  input  wire signed [kpr_pkg::StickW-1:0] in_stick_y,
  input  wire [kpr_pkg::TimeBits-1:0]      in_now_ms,
  input  wire                              in_has_focus,
  // event channel
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [kpr_pkg::SrcW-1:0]         out_key_source,
  output logic                             out_press,
  output logic                             out_auto_repeat,
  output logic                             out_last,
  // configuration
  input  wire                              cfg_we,
  input  wire [kpr_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire [kpr_pkg::CfgDataW-1:0]      cfg_wdata
);

  localparam int NS = kpr_pkg::NumSlots;
  localparam int NB = kpr_pkg::NumButtons;

  kpr_pkg::cfg_t cfg_r;

  logic [NB-1:0]  button_prev_r;
  kpr_pkg::ev_t   new_ev [NS];
  kpr_pkg::slot_t slot_q [NS];
  kpr_pkg::slot_t empty_slot;
  logic [NS:0]    later;
  logic           adv, pend_hi, accept;

  logic                      out_valid_r;
  logic [kpr_pkg::SrcW-1:0]  out_src_r;
  logic                      out_press_r, out_rep_r, out_last_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_level    <= kpr_pkg::OnLevelRst;
      cfg_r.off_level   <= kpr_pkg::OffLevelRst;
      cfg_r.delay_ms    <= kpr_pkg::DelayRst;
      cfg_r.interval_ms <= kpr_pkg::IntervalRst;
    end else if (cfg_we) begin
      case (cfg_index)
        kpr_pkg::CfgOnLevel:  cfg_r.on_level    <= cfg_wdata[kpr_pkg::AxisW-1:0];
        kpr_pkg::CfgOffLevel: cfg_r.off_level   <= cfg_wdata[kpr_pkg::AxisW-1:0];
        kpr_pkg::CfgDelay:    cfg_r.delay_ms    <= cfg_wdata[kpr_pkg::MsW-1:0];
        kpr_pkg::CfgInterval: cfg_r.interval_ms <= cfg_wdata[kpr_pkg::MsW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  // output stage advances when empty or being taken; a new sample may
  // load once that stage advances and nothing beyond the head slot is still pending
  assign adv = !out_valid_r || out_ready;

  always_comb begin
    pend_hi = 1'b0;
    for (int k = 1; k < NS; k++) begin
      pend_hi = pend_hi | slot_q[k].ev.valid;
    end
  end

  assign in_ready = adv && !pend_hi;
  assign accept   = in_valid && in_ready;

  // ---------------- button edges ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_prev_r <= '0;
    end else if (accept) begin
      button_prev_r <= in_button_levels;
    end
  end

  for (genvar b = 0; b < NB; b++) begin : g_btn
    always_comb begin
      new_ev[b].valid = in_has_focus & (in_button_levels[b] ^ button_prev_r[b]);
      new_ev[b].src   = kpr_pkg::SrcW'(b);
      new_ev[b].press = in_button_levels[b];
      new_ev[b].rep   = 1'b0;
    end
  end

  // ---------------- directions ----------------
  logic [kpr_pkg::NumDirs-1:0] dpad_bits;
  logic [kpr_pkg::NumDirs-1:0] neg_bits;
  assign dpad_bits = {in_dpad_down, in_dpad_up, in_dpad_right, in_dpad_left};
  assign neg_bits  = 4'b0101;  // left and up sit on the negative side

  for (genvar d = 0; d < kpr_pkg::NumDirs; d++) begin : g_dir
    kpr_dir u_dir (
      .clk      (clk),
      .rst_n    (rst_n),
      .accept   (accept),
      .cfg      (cfg_r),
      .dpad     (dpad_bits[d]),
      .stick    ((d < 2) ? in_stick_x : in_stick_y),
      .neg_side (neg_bits[d]),
      .now      (in_now_ms),
      .emit     (in_has_focus),
      .src      (kpr_pkg::SrcLeft + kpr_pkg::SrcW'(d)),
      .ev       (new_ev[NB+d])
    );
  end

  // ---------------- event slot chain ----------------
  assign empty_slot = '0;
  assign later[NS]  = 1'b0;

  for (genvar k = 0; k < NS; k++) begin : g_slot
    kpr_slot u_slot (
      .clk        (clk),
      .rst_n      (rst_n),
      .load       (accept),
      .shift      (adv),
      .new_ev     (new_ev[k]),
      .later_in   (later[k+1]),
      .right_slot ((k == NS-1) ? empty_slot : slot_q[(k == NS-1) ? k : k+1]),
      .later_out  (later[k]),
      .slot_q     (slot_q[k])
    );
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= slot_q[0].ev.valid;
    end
    if (adv) begin
      out_src_r   <= slot_q[0].ev.src;
      out_press_r <= slot_q[0].ev.press;
      out_rep_r   <= slot_q[0].ev.rep;
      out_last_r  <= slot_q[0].last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_source  = out_src_r;
  assign out_press       = out_press_r;
  assign out_auto_repeat = out_rep_r;
  assign out_last        = out_last_r;

  // ---------------- checks ----------------
  logic [NS-1:0] last_marks;
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      last_marks[k] = slot_q[k].ev.valid & slot_q[k].last;
    end
  end

  // at most one sample's events are in the chain
  a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(last_marks) <= 1)
    else $error("more than one last marker pending");

  // an event without the last marker is always followed by another one
  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (out_valid || pend_hi || slot_q[0].ev.valid))
    else $error("sample ended without last marker");

  // a new sample never lands on pending events
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !pend_hi)
    else $error("sample accepted over pending events");

  // releases are never repeats
  a_release_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_press) |-> !out_auto_repeat)
    else $error("release flagged as auto repeat");

endmodule

`default_nettype wire
